// ----- hw/rtl/rfcft_pkg.sv -----
// shared types and constants for the register file / coarse-fine timer block
// no dependencies
`default_nettype none

package rfcft_pkg;

	localparam int TABLE_PAIRS_DEF = 128;
	localparam int REG_COUNT = 13;
	localparam int TADDR_W = 7;
	localparam int PAIR_W = 16;

	localparam logic [3:0] REG_COARSE = 4'd1;
	localparam logic [3:0] REG_FINE = 4'd2;
	localparam logic [3:0] REG_TADDR = 4'd10;
	localparam logic [3:0] REG_TCOARSE = 4'd11;
	localparam logic [3:0] REG_TFINE = 4'd12;

	localparam logic [7:0] COARSE_TOP = 8'hff;

	localparam logic [7:0] CTL_INIT [REG_COUNT] = '{
		8'd4, 8'd123, 8'd8, 8'd127, 8'd4, 8'd9, 8'd123, 8'd8, 8'd127, 8'd254,
		8'd0, 8'd0, 8'd0
	};

	typedef enum logic [1:0] {
		CMD_SETPTR = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_EVENT  = 2'd3
	} cmd_t;

	// one pair store: coarse goes to the even byte, fine to the odd byte
	typedef struct packed {
		logic       en;
		logic [7:0] fine;
		logic [7:0] coarse;
	} pair_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rfcft_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none

module rfcft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rfcft_pair_tbl.sv -----
// pair table: ram of coarse/fine pairs with per-row valid bits and write bypass
// depends on rfcft_pkg and rfcft_ram
`default_nettype none

module rfcft_pair_tbl
	import rfcft_pkg::*;
#(
	parameter int TABLE_PAIRS = TABLE_PAIRS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pair_wr_t          pair_wr,
	input  wire logic [7:0]        taddr_cur,
	input  wire logic [7:0]        taddr_nxt,
	output logic      [PAIR_W-1:0] pair_rd
);

	localparam int ROW_W = $clog2(TABLE_PAIRS);
	localparam int MOD_N = 1 << TADDR_W;

	logic [ROW_W-1:0]       mod_tbl [MOD_N];
	logic [ROW_W-1:0]       wrow;
	logic [ROW_W-1:0]       rrow;
	logic                   hit;
	logic [TABLE_PAIRS-1:0] valid_q;
	logic                   rv_q;
	logic                   byp_q;
	logic [PAIR_W-1:0]      byp_data_q;
	logic [PAIR_W-1:0]      ram_rd;

	// pair number modulo table size, worked out at elaboration
	for (genvar i = 0; i < MOD_N; i++) begin : g_mod
		assign mod_tbl[i] = ROW_W'(i % TABLE_PAIRS);
	end

	assign wrow = mod_tbl[taddr_cur[TADDR_W-1:0]];
	// read row follows the pair address as it will stand after this edge
	assign rrow = mod_tbl[taddr_nxt[TADDR_W-1:0]];
	assign hit = pair_wr.en && (wrow == rrow);

	rfcft_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(TABLE_PAIRS)
	) u_ram (
		.clk  (clk),
		.we   (pair_wr.en),
		.waddr(wrow),
		.wdata({pair_wr.fine, pair_wr.coarse}),
		.raddr(rrow),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			if (pair_wr.en) begin
				valid_q[wrow] <= 1'b1;
			end
			rv_q <= valid_q[rrow] | hit;
			byp_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= {pair_wr.fine, pair_wr.coarse};
	end

	assign pair_rd = byp_q ? byp_data_q : (rv_q ? ram_rd : '0);

endmodule

`default_nettype wire

// ----- hw/rtl/rfcft_core.sv -----
// register file, pointer and coarse/fine timer with the result register
// depends on rfcft_pkg
`default_nettype none

module rfcft_core
	import rfcft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_vld_s1,
	input  wire logic [1:0]        cmd_s1,
	input  wire logic [7:0]        data_s1,
	input  wire logic [PAIR_W-1:0] pair_rd,
	output pair_wr_t               pair_wr,
	output logic      [7:0]        taddr_cur,
	output logic      [7:0]        taddr_nxt,
	output logic                   done,
	output logic      [7:0]        read_data,
	output logic                   pin_level,
	output logic      [7:0]        compare_top,
	output logic                   index_error
);

	logic [7:0] ctl_q [REG_COUNT];
	logic [7:0] ctl_d [REG_COUNT];
	logic [3:0] ptr_q;
	logic [3:0] ptr_d;
	logic [3:0] ptr_inc;
	logic       fine_q;
	logic       fine_d;
	logic [7:0] cnt_q;
	logic [7:0] cnt_d;
	logic [7:0] cnt_inc;
	logic       pin_q;
	logic       pin_d;
	logic [7:0] rd;
	logic       err;
	logic       restart;
	logic [7:0] coarse_new;

	logic       done_q;
	logic [7:0] read_data_q;
	logic [7:0] compare_top_q;
	logic       index_error_q;

	assign ptr_inc = (ptr_q == REG_TFINE) ? 4'd0 : ptr_q + 4'd1;
	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		ctl_d = ctl_q;
		ptr_d = ptr_q;
		fine_d = fine_q;
		cnt_d = cnt_q;
		pin_d = pin_q;
		rd = 8'd0;
		err = 1'b0;
		restart = 1'b0;
		coarse_new = ctl_q[REG_COARSE];
		pair_wr = '0;
		if (item_vld_s1) begin
			case (cmd_t'(cmd_s1))
				CMD_SETPTR: begin
					if (data_s1 >= 8'(REG_COUNT)) begin
						ptr_d = 4'd0;
						err = 1'b1;
					end else begin
						ptr_d = data_s1[3:0];
					end
				end
				CMD_WRITE: begin
					ctl_d[ptr_q] = data_s1;
					if (ptr_q <= REG_FINE) begin
						restart = 1'b1;
						if (ptr_q == REG_COARSE) begin
							coarse_new = data_s1;
						end
					end else if (ptr_q == REG_TFINE) begin
						pair_wr.en = 1'b1;
						pair_wr.coarse = ctl_q[REG_TCOARSE];
						pair_wr.fine = data_s1;
					end
					ptr_d = ptr_inc;
				end
				CMD_READ: begin
					if (ptr_q == REG_TCOARSE) begin
						rd = pair_rd[7:0];
					end else if (ptr_q == REG_TFINE) begin
						rd = pair_rd[15:8];
					end else begin
						rd = ctl_q[ptr_q];
					end
					ptr_d = ptr_inc;
				end
				CMD_EVENT: begin
					if (!fine_q) begin
						cnt_d = cnt_inc;
						if (cnt_inc >= ctl_q[REG_COARSE]) begin
							fine_d = 1'b1;
						end
					end else begin
						pin_d = ~pin_q;
						restart = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (restart) begin
			fine_d = (coarse_new == 8'd0);
			cnt_d = 8'd0;
		end
	end

	assign taddr_cur = ctl_q[REG_TADDR];
	assign taddr_nxt = ctl_d[REG_TADDR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				ctl_q[i] <= CTL_INIT[i];
			end
			ptr_q <= 4'd0;
			fine_q <= 1'b0;
			cnt_q <= 8'd0;
			pin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_q <= ctl_d;
			ptr_q <= ptr_d;
			fine_q <= fine_d;
			cnt_q <= cnt_d;
			pin_q <= pin_d;
			done_q <= item_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_vld_s1) begin
			read_data_q <= rd;
			compare_top_q <= fine_d ? ctl_d[REG_FINE] : COARSE_TOP;
			index_error_q <= err;
		end
	end

	assign done = done_q;
	assign read_data = read_data_q;
	assign pin_level = pin_q;
	assign compare_top = compare_top_q;
	assign index_error = index_error_q;

endmodule

`default_nettype wire

// ----- hw/rtl/register_file_table_coarse_fine_timer.sv -----
// top level: byte register file with pair table and coarse/fine compare timer
// depends on rfcft_pkg, rfcft_core, rfcft_pair_tbl
//
// a word (command, data_byte) is taken at a rising edge with start high and
// busy low; busy stays low, so a new word may be given in every cycle.
// the word is registered, then processed against the register file, pointer,
// pair table and timer in the next cycle.
// the result (read_data, pin_level, compare_top, index_error) shows on the
// outputs with done high for exactly one cycle, once the word has passed the
// input register and the result register; one result per word, in order,
// at one word per cycle sustained.
// the receiver cannot hold results off; none are buffered beyond that cycle.
// pair table reads go through a ram with registered read, addressed ahead of
// time from the pair address register; per-row valid bits make unwritten
// rows read as zero, so no clearing pass runs after reset.
// arst_n low restores the register defaults, pointer 0, coarse phase, pin low
// and an empty pair table, and drops any word in flight.
`default_nettype none

module register_file_table_coarse_fine_timer
	import rfcft_pkg::*;
#(
	parameter int TABLE_PAIRS = TABLE_PAIRS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] command,
	input  wire logic [7:0] data_byte,
	output logic            done,
	output logic      [7:0] read_data,
	output logic            pin_level,
	output logic      [7:0] compare_top,
	output logic            index_error
);

	logic              item_vld_s1;
	logic [1:0]        cmd_s1;
	logic [7:0]        data_s1;
	logic [PAIR_W-1:0] pair_rd;
	pair_wr_t          pair_wr;
	logic [7:0]        taddr_cur;
	logic [7:0]        taddr_nxt;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else begin
			item_vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= command;
			data_s1 <= data_byte;
		end
	end

	rfcft_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_vld_s1(item_vld_s1),
		.cmd_s1     (cmd_s1),
		.data_s1    (data_s1),
		.pair_rd    (pair_rd),
		.pair_wr    (pair_wr),
		.taddr_cur  (taddr_cur),
		.taddr_nxt  (taddr_nxt),
		.done       (done),
		.read_data  (read_data),
		.pin_level  (pin_level),
		.compare_top(compare_top),
		.index_error(index_error)
	);

	rfcft_pair_tbl #(
		.TABLE_PAIRS(TABLE_PAIRS)
	) u_pair_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair_wr  (pair_wr),
		.taddr_cur(taddr_cur),
		.taddr_nxt(taddr_nxt),
		.pair_rd  (pair_rd)
	);

endmodule

`default_nettype wire
